// ===== sv/saa_pkg.sv =====
// Shared types, constants and helpers of the segmented arena allocator.
`timescale 1ns / 1ps
package saa_pkg;

    localparam int MaxSegments = 8;
    localparam int SegIdxW     = $clog2(MaxSegments);
    localparam int SegCntW     = $clog2(MaxSegments + 1);

    localparam logic [23:0] PadMax = 24'hFFFFF8;
    localparam logic [23:0] Mask24 = 24'hFFFFFF;

    localparam logic [1:0] ST_FIT      = 2'd0;
    localparam logic [1:0] ST_NEW      = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_RELEASED = 2'd3;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] REG_INITIAL  = 2'd0;
    localparam logic [1:0] REG_INCR     = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch the input item
        logic scan;      // test one segment for room
        logic commit;    // apply the allocate outcome
        logic div_start; // start the divider
        logic rel_done;  // apply the release outcome
        logic restart;   // restart the arena
    } saa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_release;
        logic scan_last;
        logic scan_hit;
        logic need_div;
        logic div_busy;
    } saa_sts_t;

    function automatic logic [23:0] pad8(input logic [31:0] v);
        logic [32:0] p;
        begin
            p = ({1'b0, v} + 33'd7) & ~33'd7;
            pad8 = (p > {9'd0, PadMax}) ? PadMax : p[23:0];
        end
    endfunction

endpackage

// ===== sv/saa_div.sv =====
// Iterative 32 by 17 bit restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module saa_div
    import saa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [16:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);

    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [17:0] r_reg, r_next;
    logic [16:0] d_reg, d_next;
    logic [17:0] trial;

    always_comb
    begin
        cnt_next = cnt_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        trial    = {r_reg[16:0], q_reg[31]};
        if (start)
        begin
            cnt_next = 6'd32;
            q_next   = dividend;
            r_next   = 18'd0;
            d_next   = divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy     = (cnt_reg != 6'd0);
    assign quotient = q_reg;

endmodule

// ===== sv/saa_datapath.sv =====
// Segment table, tallies, first-fit scan and result register.
`timescale 1ns / 1ps
module saa_datapath
    import saa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  saa_cmd_t    cmd,
    output saa_sts_t    sts,
    input  logic [24:0] in_data,
    input  logic [23:0] initial_size,
    input  logic [23:0] increment,
    input  logic [15:0] resize_interval,
    output logic [76:0] result
);

    logic [23:0]        size_reg [MaxSegments];
    logic [23:0]        size_next [MaxSegments];
    logic [23:0]        pos_reg [MaxSegments];
    logic [23:0]        pos_next [MaxSegments];
    logic [SegCntW-1:0] cnt_reg, cnt_next;
    logic [31:0]        total_reg, total_next;
    logic [16:0]        rel_reg, rel_next;
    logic               op_reg;
    logic [23:0]        plen_reg;
    logic [SegIdxW-1:0] idx_reg, idx_next;
    logic               hit_reg, hit_next;
    logic [76:0]        res_reg, res_next;
    logic [31:0]        tenth_reg;
    logic [23:0]        room;
    logic [16:0]        rel_inc;
    logic               div_busy;
    logic [31:0]        quot;
    logic [23:0]        new_size;
    logic [23:0]        inc_pad;
    logic [32:0]        tsum;
    logic [1:0]         st;
    logic [2:0]         seg_o;
    logic [23:0]        off_o;

    saa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (total_reg),
        .divisor  (rel_inc),
        .busy     (div_busy),
        .quotient (quot)
    );

    assign rel_inc = rel_reg + 17'd1;
    assign room    = (size_reg[idx_reg] >= pos_reg[idx_reg])
                     ? size_reg[idx_reg] - pos_reg[idx_reg] : 24'd0;
    assign inc_pad = pad8({8'd0, increment});

    always_comb
    begin
        new_size = plen_reg;
        if (new_size < inc_pad)
        begin
            new_size = inc_pad;
        end
        if ({8'd0, new_size} < tenth_reg)
        begin
            new_size = pad8(tenth_reg);
        end
    end

    always_comb
    begin
        size_next  = size_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        rel_next   = rel_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        res_next   = res_reg;
        tsum       = {1'b0, total_reg} + {9'd0, plen_reg};
        st         = ST_FIT;
        seg_o      = 3'd0;
        off_o      = 24'd0;
        if (cmd.restart)
        begin
            for (int i = 0; i < MaxSegments; i++)
            begin
                size_next[i] = 24'd0;
                pos_next[i]  = 24'd0;
            end
            size_next[0] = pad8({8'd0, initial_size});
            cnt_next     = SegCntW'(1);
            total_next   = 32'd0;
            rel_next     = 17'd0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_next = '0;
                hit_next = 1'b0;
            end
            if (cmd.scan)
            begin
                if (room >= plen_reg)
                begin
                    hit_next = 1'b1;
                end
                else if (({1'b0, idx_reg} + SegCntW'(1)) < cnt_reg)
                begin
                    idx_next = idx_reg + SegIdxW'(1);
                end
            end
            if (cmd.commit)
            begin
                if (hit_reg)
                begin
                    st    = ST_FIT;
                    seg_o = 3'(idx_reg);
                    off_o = pos_reg[idx_reg];
                    pos_next[idx_reg] = pos_reg[idx_reg] + plen_reg;
                end
                else if (cnt_reg >= SegCntW'(MaxSegments))
                begin
                    st = ST_FULL;
                end
                else
                begin
                    st = ST_NEW;
                    seg_o = 3'(cnt_reg);
                    size_next[cnt_reg[SegIdxW-1:0]] = new_size;
                    pos_next[cnt_reg[SegIdxW-1:0]]  = plen_reg;
                    cnt_next = cnt_reg + SegCntW'(1);
                end
                if (st != ST_FULL)
                begin
                    total_next = tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
                end
                res_next = {size_next[0], plen_reg, off_o, seg_o, st};
            end
            if (cmd.rel_done)
            begin
                rel_next = rel_inc;
                if (sts.need_div)
                begin
                    size_next[0] = (quot > {8'd0, Mask24}) ? Mask24 : quot[23:0];
                    total_next   = 32'd0;
                    rel_next     = 17'd0;
                end
                pos_next[0] = 24'd0;
                for (int i = 1; i < MaxSegments; i++)
                begin
                    size_next[i] = 24'd0;
                    pos_next[i]  = 24'd0;
                end
                cnt_next = SegCntW'(1);
                res_next = {size_next[0], 24'd0, 24'd0, 3'd0, ST_RELEASED};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MaxSegments; i++)
            begin
                size_reg[i] <= 24'd0;
                pos_reg[i]  <= 24'd0;
            end
            size_reg[0] <= 24'd4096;
            cnt_reg     <= SegCntW'(1);
            total_reg   <= 32'd0;
            rel_reg     <= 17'd0;
        end
        else
        begin
            size_reg  <= size_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
            rel_reg   <= rel_next;
        end
    end

    // The divide by ten is a reciprocal multiply; it is registered at load.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        hit_reg <= hit_next;
        res_reg <= res_next;
        if (cmd.load)
        begin
            op_reg    <= in_data[0];
            plen_reg  <= pad8({8'd0, in_data[24:1]});
            tenth_reg <= 32'((64'(total_reg) * 64'hCCCCCCCD) >> 35);
        end
    end

    assign sts.is_release = (op_reg == OP_RELEASE);
    assign sts.scan_last  = hit_next || ({1'b0, idx_reg} + SegCntW'(1) >= cnt_reg);
    assign sts.scan_hit   = hit_reg;
    assign sts.need_div   = (rel_inc > {1'b0, resize_interval}) && (rel_inc != 17'd0);
    assign sts.div_busy   = div_busy;
    assign result         = res_reg;

endmodule

// ===== sv/saa_ctrl.sv =====
// Controller state machine and stream handshakes.
`timescale 1ns / 1ps
module saa_ctrl
    import saa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    input  logic     out_ready,
    input  logic     cfg_restart,
    input  saa_sts_t sts,
    output saa_cmd_t cmd,
    output logic     in_ready,
    output logic     out_valid
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_COMMIT = 3'd2;
    localparam logic [2:0] S_DIV = 3'd3;
    localparam logic [2:0] S_REL = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;
    localparam logic [2:0] S_DISP = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       div_wait_reg, div_wait_next;

    always_comb
    begin
        state_next    = state_reg;
        div_wait_next = 1'b0;
        cmd           = '0;
        cmd.restart   = cfg_restart;
        in_ready      = (state_reg == S_IDLE);
        out_valid     = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.is_release)
                begin
                    if (sts.need_div)
                    begin
                        cmd.div_start = 1'b1;
                        div_wait_next = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        state_next = S_REL;
                    end
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_DIV:
            begin
                if (!div_wait_reg && !sts.div_busy)
                begin
                    state_next = S_REL;
                end
            end
            S_REL:
            begin
                cmd.rel_done = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            div_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            div_wait_reg <= div_wait_next;
        end
    end

endmodule

// ===== sv/segmented_arena_allocator.sv =====
// Top level of the segmented arena allocator.
// Allocate: dispatch, then a first-fit scan that tests one segment at a time (1 to 8 segments), then commit.
// Release: dispatch, then release; when a resize is due, the 32-step serial divider runs before the release.
// One item is in flight at a time; a new item is taken after the result transfer.
// Reset clears the table to the register reset values; segment 0 is 4096 bytes.
`timescale 1ns / 1ps
module segmented_arena_allocator
    import saa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operation [0], length [24:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // status, segment, offset, padded_length, first_size
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    saa_cmd_t    cmd;
    saa_sts_t    sts;
    logic [23:0] init_reg, incr_reg;
    logic [15:0] intv_reg;
    logic        wr;
    logic        restart;
    logic [76:0] result;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign restart = wr && (paddr[3:2] == REG_INITIAL) && (paddr[1:0] == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= 24'd4096;
            incr_reg <= 24'd1024;
            intv_reg <= 16'd16;
        end
        else if (wr && paddr[1:0] == 2'd0)
        begin
            case (paddr[3:2])
                REG_INITIAL:  init_reg <= pwdata[23:0];
                REG_INCR:     incr_reg <= pwdata[23:0];
                REG_INTERVAL: intv_reg <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_INITIAL:  prdata = {8'd0, init_reg};
            REG_INCR:     prdata = {8'd0, incr_reg};
            REG_INTERVAL: prdata = {16'd0, intv_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // Restart uses the value being written, since the register updates at the same edge.
    logic [23:0] init_eff;
    assign init_eff = restart ? pwdata[23:0] : init_reg;

    saa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (s_tvalid && s_tready),
        .out_ready   (m_tready),
        .cfg_restart (restart),
        .sts         (sts),
        .cmd         (cmd),
        .in_ready    (s_tready),
        .out_valid   (m_tvalid)
    );

    saa_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_data         (s_tdata[24:0]),
        .initial_size    (init_eff),
        .increment       (incr_reg),
        .resize_interval (intv_reg),
        .result          (result)
    );

    assign m_tdata = {3'd0, result};

endmodule

// ===== sv/saa_checker.sv =====
// Port-level checker for the segmented arena allocator, bound to the top level.
`timescale 1ns / 1ps
module saa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result without processing");

    a_release_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == 2'd3 |-> m_tdata[52:2] == 51'd0)
        else $error("release result fields not zero");

endmodule

bind segmented_arena_allocator saa_checker u_saa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
